@@ hw/rtl/nss_pkg.sv @@
// ----------------------------------------------------------------------------
// nss_pkg
// Shared constants and types for the nearest segment search block.
// ----------------------------------------------------------------------------
package nss_pkg;

    // Fixed field widths
    localparam int COORD_W    = 24;
    localparam int IDX_OUT_W  = 8;
    localparam int OFF_OUT_W  = 17;
    localparam int DIST_OUT_W = 51;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Query request handed to the search engine
    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic                      limited;
        logic [COORD_W-1:0]        max_distance;
    } t_nss_query;

    // Search result from the engine
    typedef struct packed {
        logic                  found;
        logic [IDX_OUT_W-1:0]  segment_index;
        logic [OFF_OUT_W-1:0]  offset;
        logic [DIST_OUT_W-1:0] distance_sq;
    } t_nss_result;

endpackage

@@ hw/rtl/nss_if.sv @@
// ----------------------------------------------------------------------------
// nss_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface nss_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [23:0] end1_x;
    logic signed [23:0] end1_y;
    logic signed [23:0] end2_x;
    logic signed [23:0] end2_y;
    logic signed [23:0] query_x;
    logic signed [23:0] query_y;
    logic               limit_enabled;
    logic [23:0]        max_distance;

    modport source (output valid, cmd, end1_x, end1_y, end2_x, end2_y, query_x, query_y,
                    limit_enabled, max_distance, input ready);
    modport sink   (input valid, cmd, end1_x, end1_y, end2_x, end2_y, query_x, query_y,
                    limit_enabled, max_distance, output ready);
endinterface

interface nss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  segment_index;
    logic [16:0] offset;
    logic [50:0] distance_sq;
    logic        table_full;

    modport source (output valid, found, segment_index, offset, distance_sq, table_full,
                    input ready);
    modport sink   (input valid, found, segment_index, offset, distance_sq, table_full,
                    output ready);
endinterface

@@ hw/rtl/nss_seg_mem.sv @@
// ----------------------------------------------------------------------------
// nss_seg_mem
// Segment endpoint storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nss_seg_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [47:0]   i_wdata1,
    input  logic [47:0]   i_wdata2,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [47:0]   o_rdata1,
    output logic [47:0]   o_rdata2
);
    logic [47:0] r_first  [DEPTH];
    logic [47:0] r_second [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_first[i_waddr]  <= i_wdata1;
            r_second[i_waddr] <= i_wdata2;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata1 <= r_first[i_raddr];
            o_rdata2 <= r_second[i_raddr];
        end
    end
endmodule

@@ hw/rtl/nss_engine.sv @@
// ----------------------------------------------------------------------------
// nss_engine
// Walks the stored segments, projects the query point onto each one with a
// bit-serial divider and keeps the strictly nearest.
// ----------------------------------------------------------------------------
module nss_engine #(
    parameter int OFFSET_FRAC_BITS = 16,
    parameter int CW               = 9,
    parameter int AW               = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  nss_pkg::t_nss_query  i_query,
    input  logic [CW-1:0]        i_count,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [47:0]          i_rd_first,
    input  logic [47:0]          i_rd_second,
    output logic                 o_idle,
    output logic                 o_done,
    output nss_pkg::t_nss_result o_result
);
    import nss_pkg::*;

    localparam int TW = OFFSET_FRAC_BITS + 1;
    localparam int KW = $clog2(OFFSET_FRAC_BITS + 1);
    localparam int QW = TW + 26;
    localparam logic [TW-1:0] HALF_T = TW'(1) << (OFFSET_FRAC_BITS - 1);
    localparam logic [TW-1:0] ONE_T  = TW'(1) << OFFSET_FRAC_BITS;
    localparam logic [KW-1:0] K_LAST = KW'(OFFSET_FRAC_BITS - 1);

    typedef enum logic [11:0] {
        E_IDLE = 12'b000000000001,
        E_INIT = 12'b000000000010,
        E_RD   = 12'b000000000100,
        E_LD   = 12'b000000001000,
        E_MUL  = 12'b000000010000,
        E_SUM  = 12'b000000100000,
        E_DEC  = 12'b000001000000,
        E_DIV  = 12'b000010000000,
        E_PROJ = 12'b000100000000,
        E_DXY  = 12'b001000000000,
        E_SQ   = 12'b010000000000,
        E_CMP  = 12'b100000000000
    } t_estate;

    t_estate r_state;
    logic    r_done;

    logic [CW-1:0]      r_idx, r_cnt, r_best_idx;
    logic signed [23:0] r_qx, r_qy;
    logic               r_limited, r_have, r_zl;
    logic [23:0]        r_md;
    logic [54:0]        r_best;
    logic [TW-1:0]      r_best_t, r_t;
    logic signed [24:0] r_abx, r_aby, r_wx, r_wy;
    logic signed [49:0] r_p0, r_p1, r_p2, r_p3;
    logic [50:0]        r_len2, r_rem;
    logic signed [50:0] r_num;
    logic [KW-1:0]      r_k;
    logic signed [QW-1:0] r_q0, r_q1;
    logic signed [26:0] r_dx, r_dy;
    logic signed [53:0] r_d0, r_d1;

    logic signed [QW-1:0] q0_sh, q1_sh;
    logic [50:0]          rem2;
    logic [54:0]          cand_dist;
    logic [CW-1:0]        idx_nxt;
    logic signed [23:0]   ax, ay, bx, by;
    logic [TW+OFF_OUT_W-1:0] t_ext;
    logic [CW+IDX_OUT_W-1:0] idx_ext;

    // datapath helpers
    assign ax        = i_rd_first[47:24];
    assign ay        = i_rd_first[23:0];
    assign bx        = i_rd_second[47:24];
    assign by        = i_rd_second[23:0];
    assign q0_sh     = r_q0 >>> OFFSET_FRAC_BITS;
    assign q1_sh     = r_q1 >>> OFFSET_FRAC_BITS;
    assign rem2      = {r_rem[49:0], 1'b0};
    assign cand_dist = {1'b0, r_d0} + {1'b0, r_d1};
    assign idx_nxt   = r_idx + CW'(1);

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                E_IDLE: if (i_start) r_state <= E_INIT;
                E_INIT: begin
                    if (r_cnt == '0) begin
                        r_state <= E_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= E_RD;
                    end
                end
                E_RD:   r_state <= E_LD;
                E_LD:   r_state <= E_MUL;
                E_MUL:  r_state <= E_SUM;
                E_SUM:  r_state <= E_DEC;
                E_DEC: begin
                    if (r_len2 == '0 || r_num[50] || r_num == '0 ||
                        $unsigned(r_num) >= r_len2) begin
                        r_state <= E_PROJ;
                    end else begin
                        r_state <= E_DIV;
                    end
                end
                E_DIV:  if (r_k == K_LAST) r_state <= E_PROJ;
                E_PROJ: r_state <= E_DXY;
                E_DXY:  r_state <= E_SQ;
                E_SQ:   r_state <= E_CMP;
                E_CMP: begin
                    if (idx_nxt == r_cnt) begin
                        r_state <= E_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= E_RD;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    // search bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            case (r_state)
                E_IDLE: if (i_start) r_have <= 1'b0;
                E_CMP: begin
                    if ((!r_limited && !r_have) || cand_dist < r_best) r_have <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                r_qx      <= i_query.qx;
                r_qy      <= i_query.qy;
                r_limited <= i_query.limited;
                r_md      <= i_query.max_distance;
                r_cnt     <= i_count;
                r_idx     <= '0;
            end
            E_INIT: begin
                r_best     <= 55'(r_md * r_md);
                r_best_t   <= HALF_T;
                r_best_idx <= '0;
            end
            E_LD: begin
                r_abx <= 25'(bx) - 25'(ax);
                r_aby <= 25'(by) - 25'(ay);
                r_wx  <= 25'(r_qx) - 25'(ax);
                r_wy  <= 25'(r_qy) - 25'(ay);
            end
            E_MUL: begin
                r_p0 <= r_abx * r_abx;
                r_p1 <= r_aby * r_aby;
                r_p2 <= r_wx * r_abx;
                r_p3 <= r_wy * r_aby;
            end
            E_SUM: begin
                r_len2 <= {1'b0, r_p0} + {1'b0, r_p1};
                r_num  <= 51'(r_p2) + 51'(r_p3);
            end
            E_DEC: begin
                r_zl  <= (r_len2 == '0);
                r_rem <= $unsigned(r_num);
                r_k   <= '0;
                if (r_len2 == '0)                    r_t <= HALF_T;
                else if (r_num[50] || r_num == '0)   r_t <= '0;
                else if ($unsigned(r_num) >= r_len2) r_t <= ONE_T;
                else                                 r_t <= '0;
            end
            E_DIV: begin
                // one quotient bit per cycle, restoring
                r_k <= r_k + KW'(1);
                if (rem2 >= r_len2) begin
                    r_rem <= rem2 - r_len2;
                    r_t   <= {r_t[TW-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_t   <= {r_t[TW-2:0], 1'b0};
                end
            end
            E_PROJ: begin
                r_q0 <= QW'(r_abx) * $signed({1'b0, r_t});
                r_q1 <= QW'(r_aby) * $signed({1'b0, r_t});
            end
            E_DXY: begin
                if (r_zl) begin
                    r_dx <= 27'(r_wx);
                    r_dy <= 27'(r_wy);
                end else begin
                    r_dx <= 27'(r_wx) - q0_sh[26:0];
                    r_dy <= 27'(r_wy) - q1_sh[26:0];
                end
            end
            E_SQ: begin
                r_d0 <= r_dx * r_dx;
                r_d1 <= r_dy * r_dy;
            end
            E_CMP: begin
                r_idx <= idx_nxt;
                if ((!r_limited && !r_have) || cand_dist < r_best) begin
                    r_best     <= cand_dist;
                    r_best_t   <= r_t;
                    r_best_idx <= r_idx;
                end
            end
            default: ;
        endcase
    end

    // memory read and result
    assign o_rd_en   = (r_state == E_RD);
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_idle    = (r_state == E_IDLE);
    assign o_done    = r_done;

    assign t_ext   = {{OFF_OUT_W{1'b0}}, (r_have ? r_best_t : HALF_T)};
    assign idx_ext = {{IDX_OUT_W{1'b0}}, (r_have ? r_best_idx : CW'(0))};

    always_comb begin
        o_result.found         = r_have;
        o_result.segment_index = idx_ext[IDX_OUT_W-1:0];
        o_result.offset        = t_ext[OFF_OUT_W-1:0];
        o_result.distance_sq   = r_have ? r_best[DIST_OUT_W-1:0] : '0;
    end
endmodule

@@ hw/rtl/nearest_segment_search.sv @@
// Timing: a clear or append result is registered into the output register; a query
//   walks all N stored segments in turn, with one memory read, multiply stages and
//   the bit-serial divider for each; a segment whose t clamps or that has zero length skips the divider.
// Throughput: one item at a time; no new item is accepted until a query has finished
//   and the output slot is free or being taken.
// Reset: synchronous active low; clears the segment count and control state.
// ----------------------------------------------------------------------------
// nearest_segment_search
// Segment table with a sequential nearest segment query.
// ----------------------------------------------------------------------------
module nearest_segment_search #(
    parameter int MAX_SEGMENTS     = 256,
    parameter int OFFSET_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nss_in_if.sink    i_in,
    nss_out_if.source o_out
);
    import nss_pkg::*;

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int TW = OFFSET_FRAC_BITS + 1;
    localparam logic [TW-1:0] HALF_T = TW'(1) << (OFFSET_FRAC_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    logic          n_out_valid;

    logic          accept, full, mem_we, eng_re, eng_idle, eng_done;
    logic [AW-1:0] eng_addr;
    logic [47:0]   rd_first, rd_second;
    t_nss_query    query;
    t_nss_result   eng_res;
    logic [TW+OFF_OUT_W-1:0] half_ext;

    assign full     = (r_count == CW'(MAX_SEGMENTS));
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign accept   = i_in.valid && i_in.ready;
    assign mem_we   = accept && (i_in.cmd == CMD_APPEND) && !full;
    assign half_ext = {{OFF_OUT_W{1'b0}}, HALF_T};

    always_comb begin
        query.qx           = i_in.query_x;
        query.qy           = i_in.query_y;
        query.limited      = i_in.limit_enabled;
        query.max_distance = i_in.max_distance;
    end

    nss_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (r_count[AW-1:0]),
        .i_wdata1 ({i_in.end1_x, i_in.end1_y}),
        .i_wdata2 ({i_in.end2_x, i_in.end2_y}),
        .i_re     (eng_re),
        .i_raddr  (eng_addr),
        .o_rdata1 (rd_first),
        .o_rdata2 (rd_second)
    );

    nss_engine #(.OFFSET_FRAC_BITS(OFFSET_FRAC_BITS), .CW(CW), .AW(AW)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && (i_in.cmd == CMD_QUERY)),
        .i_query     (query),
        .i_count     (r_count),
        .o_rd_en     (eng_re),
        .o_rd_addr   (eng_addr),
        .i_rd_first  (rd_first),
        .i_rd_second (rd_second),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_result    (eng_res)
    );

    // output slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.valid && o_out.ready) n_out_valid = 1'b0;
        if (accept && i_in.cmd != CMD_QUERY) n_out_valid = 1'b1;
        if (eng_done) n_out_valid = 1'b1;
    end

    // command control and segment count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in.cmd == CMD_QUERY) begin
                            r_state <= S_BUSY;
                        end else begin
                            if (i_in.cmd == CMD_CLEAR) r_count <= '0;
                            if (mem_we) r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_BUSY: begin
                    if (eng_done) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (accept && i_in.cmd != CMD_QUERY) begin
            o_out.found         <= 1'b0;
            o_out.segment_index <= '0;
            o_out.offset        <= half_ext[OFF_OUT_W-1:0];
            o_out.distance_sq   <= '0;
            o_out.table_full    <= (i_in.cmd == CMD_APPEND) && full;
        end else if (eng_done) begin
            o_out.found         <= eng_res.found;
            o_out.segment_index <= eng_res.segment_index;
            o_out.offset        <= eng_res.offset;
            o_out.distance_sq   <= eng_res.distance_sq;
            o_out.table_full    <= 1'b0;
        end
    end

    assign o_out.valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_engine_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> eng_idle)
        else $error("item accepted while search engine busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count beyond table size");
    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (!r_out_valid && r_state == S_BUSY))
        else $error("search finished with output slot occupied");
`endif
endmodule

@@ tb/nss_checker.sv @@
// ----------------------------------------------------------------------------
// nss_checker
// Watches the command and result channels of the nearest segment search, keeps
// its own segment table, works out the result of each accepted command item
// and compares every accepted result item, field by field, in order.
// ----------------------------------------------------------------------------
module nss_checker #(
    parameter int MAX_SEGMENTS     = 256,
    parameter int OFFSET_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nss_in_if    i_in,
    nss_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nss_pkg::*;

    typedef struct packed {
        logic                  found;
        logic [IDX_OUT_W-1:0]  segment_index;
        logic [OFF_OUT_W-1:0]  offset;
        logic [DIST_OUT_W-1:0] distance_sq;
        logic                  table_full;
    } t_answer;

    localparam longint HALF_T = longint'(1) << (OFFSET_FRAC_BITS - 1);
    localparam longint ONE_T  = longint'(1) << OFFSET_FRAC_BITS;

    logic signed [23:0] seg_ax [MAX_SEGMENTS];
    logic signed [23:0] seg_ay [MAX_SEGMENTS];
    logic signed [23:0] seg_bx [MAX_SEGMENTS];
    logic signed [23:0] seg_by [MAX_SEGMENTS];
    int      seg_count;
    t_answer answers_due[$];

    assign o_pending = answers_due.size();

    // append an expected result item at the tail
    function automatic void due_add(t_answer a);
        answers_due = {answers_due, a};
    endfunction

    function automatic t_answer idle_answer(logic full);
        t_answer a;
        a = '0;
        a.offset     = OFF_OUT_W'(HALF_T);
        a.table_full = full;
        return a;
    endfunction

    // floor division by 2^F, rounding toward minus infinity
    function automatic longint floor_frac(longint v);
        return v >>> OFFSET_FRAC_BITS;
    endfunction

    // project the query point on every stored segment, keep the first nearest
    function automatic t_answer nearest_answer(longint qx, longint qy, logic limited,
                                               longint md);
        t_answer a;
        longint  best, best_t, ax, ay, abx, aby, wx, wy, len2, num, t, dx, dy;
        longint  seg_dist;
        int      best_i;
        bit      have;
        best = limited ? md * md : 0;
        best_t = HALF_T;
        best_i = 0;
        have = 0;
        for (int i = 0; i < seg_count; i++) begin
            ax = seg_ax[i];
            ay = seg_ay[i];
            abx = longint'(seg_bx[i]) - ax;
            aby = longint'(seg_by[i]) - ay;
            wx = qx - ax;
            wy = qy - ay;
            len2 = abx * abx + aby * aby;
            if (len2 == 0) begin
                t = HALF_T;
                dx = wx;
                dy = wy;
            end else begin
                num = wx * abx + wy * aby;
                if (num <= 0) t = 0;
                else if (num >= len2) t = ONE_T;
                else t = longint'((128'(num) << OFFSET_FRAC_BITS) / 128'(len2));
                dx = wx - floor_frac(abx * t);
                dy = wy - floor_frac(aby * t);
            end
            seg_dist = dx * dx + dy * dy;
            if ((!limited && !have) || (seg_dist < best)) begin
                best = seg_dist;
                best_t = t;
                best_i = i;
                have = 1;
            end
        end
        if (!have) return idle_answer(1'b0);
        a = '0;
        a.found         = 1'b1;
        a.segment_index = IDX_OUT_W'(best_i);
        a.offset        = OFF_OUT_W'(best_t);
        a.distance_sq   = DIST_OUT_W'(best);
        return a;
    endfunction

    // prediction on accepted command items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_count = 0;
            answers_due.delete();
        end else if (i_in.valid && i_in.ready) begin
            case (i_in.cmd)
                CMD_CLEAR: begin
                    seg_count = 0;
                    due_add(idle_answer(1'b0));
                end
                CMD_APPEND: begin
                    if (seg_count >= MAX_SEGMENTS) begin
                        due_add(idle_answer(1'b1));
                    end else begin
                        seg_ax[seg_count] = i_in.end1_x;
                        seg_ay[seg_count] = i_in.end1_y;
                        seg_bx[seg_count] = i_in.end2_x;
                        seg_by[seg_count] = i_in.end2_y;
                        seg_count++;
                        due_add(idle_answer(1'b0));
                    end
                end
                CMD_QUERY: begin
                    due_add(nearest_answer(i_in.query_x, i_in.query_y,
                                           i_in.limit_enabled,
                                           longint'(i_in.max_distance)));
                end
                default: due_add(idle_answer(1'b0));
            endcase
        end
    end

    // compare accepted result items
    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else if (i_out.valid && i_out.ready) begin
            got = {i_out.found, i_out.segment_index, i_out.offset, i_out.distance_sq,
                   i_out.table_full};
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result item %p", $realtime, got);
                o_errors <= o_errors + 1;
            end else begin
                want = answers_due.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    o_errors <= o_errors + 1;
                end
            end
        end
    end
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, append, query and reserved-code items into the nearest segment
// search with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nss_pkg::*;

    // command code with no function
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   src_idle, snk_stall;

    nss_in_if  in_ch();
    nss_out_if out_ch();

    nearest_segment_search dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch),
                                .o_out(out_ch));
    nss_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
                     .o_errors(errors), .o_pending(pending));

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= snk_stall);

    // small coordinates half the time so distances are comparable, else random or extreme
    function automatic logic [23:0] rnd_coord();
        case ($urandom_range(3))
            0:       return 24'($urandom);
            1:       return $urandom_range(1) ? 24'h7fffff : 24'h800000;
            default: return 24'(int'($urandom_range(8000)) - 4000);
        endcase
    endfunction

    // valid stays up between back-to-back items and drops only while idling
    task automatic send(logic [1:0] cmd, logic [23:0] x1, y1, x2, y2, qx, qy,
                        logic lim, logic [23:0] md);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.end1_x <= x1;
        in_ch.end1_y <= y1;
        in_ch.end2_x <= x2;
        in_ch.end2_y <= y2;
        in_ch.query_x <= qx;
        in_ch.query_y <= qy;
        in_ch.limit_enabled <= lim;
        in_ch.max_distance <= md;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(int append_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            send(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        else if (r < 4)
            send(CMD_RESERVED, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 24'($urandom), 1'($urandom), 24'($urandom));
        else if (r < append_pct)
            send(CMD_APPEND, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), 1'($urandom), 24'($urandom));
        else
            send(CMD_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), 1'($urandom),
                 $urandom_range(1) ? 24'($urandom_range(3000)) : 24'($urandom));
    endtask

    initial begin
        int wait_cycles;
        src_idle = 0;
        snk_stall = 0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_CLEAR;
        {in_ch.end1_x, in_ch.end1_y, in_ch.end2_x, in_ch.end2_y} = '0;
        {in_ch.query_x, in_ch.query_y, in_ch.limit_enabled, in_ch.max_distance} = '0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, zero-length, zero limit, unused command
        send(CMD_QUERY, '0, '0, '0, '0, 24'h7fffff, 24'h800000, 1'b0, '0);
        send(CMD_APPEND, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, '0, '0, 1'b0, '0);
        send(CMD_APPEND, 24'd100, 24'd100, 24'd100, 24'd100, '0, '0, 1'b0, '0);
        send(CMD_APPEND, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, '0, '0, 1'b0, '0);
        send(CMD_QUERY, '0, '0, '0, '0, 24'd100, 24'd100, 1'b0, '0);
        send(CMD_QUERY, '0, '0, '0, '0, 24'h7fffff, 24'h7fffff, 1'b0, '0);
        send(CMD_QUERY, '0, '0, '0, '0, 24'h800000, 24'h7fffff, 1'b1, 24'hffffff);
        send(CMD_QUERY, '0, '0, '0, '0, 24'd100, 24'd100, 1'b1, '0);
        send(CMD_QUERY, '0, '0, '0, '0, 24'd5000, 24'd7, 1'b1, 24'd10);
        send(CMD_RESERVED, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
             24'hffffff, 1'b1, 24'hffffff);
        send(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        send(CMD_QUERY, '0, '0, '0, '0, 24'd1, 24'd1, 1'b0, '0);
        // fill the table to capacity, overflow it, query the full table
        for (int i = 0; i < 258; i++)
            send(CMD_APPEND, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 '0, '0, 1'b0, '0);
        send(CMD_QUERY, '0, '0, '0, '0, rnd_coord(), rnd_coord(), 1'b0, '0);
        send(CMD_QUERY, '0, '0, '0, '0, rnd_coord(), rnd_coord(), 1'b1, 24'd2000);
        send(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, '0);

        // random phases; queries on small tables keep the run short
        for (int ph = 0; ph < 4; ph++) begin
            src_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 76) : 0;
            snk_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 76) : 0;
            for (int n = 0; n < 310; n++) send_random(50);
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end
endmodule
